>>> hdl/lae_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lae_pkg: shared types and constants for the linear ADSR envelope core
// Function codes, register indexes, sequencer states and reset values.
// ---------------------------------------------------------------------------
package lae_pkg;

	localparam int DEF_TIME_BITS  = 32;
	localparam int DEF_LEVEL_BITS = 16;

	localparam int FUNC_BITS      = 2;
	localparam int TICK_BITS      = 24;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = TICK_BITS;
	localparam int IN_TIME_BITS   = 32;  // tick time arrives as a 32-bit counter
	localparam int CFG_LEVEL_BITS = 16;  // level registers take 16 bits of data

	localparam logic [TICK_BITS-1:0] ATTACK_RESET  = 24'd4800;
	localparam logic [TICK_BITS-1:0] DECAY_RESET   = 24'd4800;
	localparam logic [TICK_BITS-1:0] RELEASE_RESET = 24'd9600;
	localparam logic [CFG_LEVEL_BITS-1:0] SUSTAIN_RESET = 16'd52428;
	localparam logic [CFG_LEVEL_BITS-1:0] PEAK_RESET    = 16'd65535;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_SAMPLE   = 2'd0,
		FUNC_NOTE_ON  = 2'd1,
		FUNC_NOTE_OFF = 2'd2,
		FUNC_RESET    = 2'd3
	} func_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_SUSTAIN = 3'd2,
		REG_RELEASE = 3'd3,
		REG_PEAK    = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	// How the quotient combines with the base level
	typedef enum logic [1:0] {
		MODE_DIRECT,
		MODE_ADD,
		MODE_SUB
	} mode_t;

endpackage

>>> hdl/lae_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lae_div: shared restoring divider
// One quotient bit per cycle. The caller guarantees the quotient fits in
// QUO_BITS bits, so the upper dividend bits seed the partial remainder.
// ---------------------------------------------------------------------------
module lae_div #(
	parameter int DEN_BITS = lae_pkg::TICK_BITS,
	parameter int QUO_BITS = lae_pkg::DEF_LEVEL_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DEN_BITS+QUO_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0]          divisor,
	output logic                         done,
	output logic [QUO_BITS-1:0]          quotient
);

	localparam int CntBits = $clog2(QUO_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CntBits-1:0]  cnt_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [QUO_BITS-1:0] quo_q;

	logic [DEN_BITS:0]   cand;
	logic [DEN_BITS:0]   diff;
	logic                ge;

	// Shift the next dividend bit into the remainder and try the subtract
	always_comb begin
		cand = {rem_q, quo_q[QUO_BITS-1]};
		diff = cand - {1'b0, den_q};
		ge   = (cand >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// flag the cycle after the last quotient bit
			done_q <= !start && busy_q && (cnt_q == CntBits'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(QUO_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DEN_BITS+QUO_BITS-1:QUO_BITS];
			quo_q <= dividend[QUO_BITS-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_BITS-1:0] : cand[DEN_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/linear_adsr_envelope_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_adsr_envelope_core: linear attack/decay/sustain/release envelope
// Sequencer around one multiplier stage and a shared serial divider.
// ---------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------
// in       | in_valid / in_ready  | func, time_now
// out      | out_valid / out_ready| level, released
// cfg      | cfg_we               | cfg_index, cfg_data
//
// A sample on a ramp passes from acceptance through the evaluate, multiply,
// divide and done states, the divider producing one quotient bit a cycle.
// Flat samples and the note on, note off and reset codes skip multiply and divide.
// One transaction is in flight at a time; in_ready is high only when idle.
// A finished result waits in the output register; a new result is held back
// until that register is free. Reset restores configuration, envelope and sequencer state and out_valid.
// ---------------------------------------------------------------------------
module linear_adsr_envelope_core #(
	parameter int TIME_BITS  = lae_pkg::DEF_TIME_BITS,
	parameter int LEVEL_BITS = lae_pkg::DEF_LEVEL_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lae_pkg::FUNC_BITS-1:0]      func,
	input  logic [TIME_BITS-1:0]               time_now,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [LEVEL_BITS-1:0]              level,
	output logic                               released,
	input  logic                               cfg_we,
	input  logic [lae_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lae_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int TickBits  = lae_pkg::TICK_BITS;
	localparam int CmpBits   = (TIME_BITS > TickBits + 1) ? TIME_BITS : TickBits + 1;
	localparam int InTimeW   = (TIME_BITS < lae_pkg::IN_TIME_BITS) ?
	                           TIME_BITS : lae_pkg::IN_TIME_BITS;
	localparam int CfgLevelW = (LEVEL_BITS < lae_pkg::CFG_LEVEL_BITS) ?
	                           LEVEL_BITS : lae_pkg::CFG_LEVEL_BITS;
	localparam int LowCut    = (2 ** LEVEL_BITS) / 10000;

	// Configuration registers
	logic [TickBits-1:0]   attack_q, decay_q, release_q;
	logic [LEVEL_BITS-1:0] sustain_q, peak_q;

	// Envelope state
	logic                  gate_q;
	logic [TIME_BITS-1:0]  on_q, off_q;
	logic [LEVEL_BITS-1:0] held_q, last_q;

	// Sequencer and working registers
	lae_pkg::state_t       state_q, state_d;
	lae_pkg::func_t        func_q;
	logic [TIME_BITS-1:0]  now_q;
	lae_pkg::mode_t        mode_q;
	logic [LEVEL_BITS-1:0] base_q;
	logic [TickBits-1:0]   mul_a_q;
	logic [LEVEL_BITS-1:0] mul_b_q;
	logic [TickBits-1:0]   div_den_q;

	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic                  released_q;

	// Evaluation
	lae_pkg::mode_t        ev_mode;
	logic [LEVEL_BITS-1:0] ev_base;
	logic [TickBits-1:0]   ev_a;
	logic [LEVEL_BITS-1:0] ev_b;
	logic [TickBits-1:0]   ev_den;
	logic [TIME_BITS-1:0]  elapsed;
	logic [CmpBits-1:0]    t_w, a_w, ad_w, r_w, dt_w;
	logic                  rising;

	// Control outputs of the sequencer
	logic                  accept;
	logic                  div_start;
	logic                  div_done;
	logic                  commit;
	logic [LEVEL_BITS-1:0] quotient;
	logic [TickBits+LEVEL_BITS-1:0] product;

	// Result assembly
	logic [LEVEL_BITS-1:0] lvl;
	logic [LEVEL_BITS-1:0] lvl_cut;

	assign accept = in_valid && in_ready;

	// -----------------------------------------------------------------------
	// Configuration
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= lae_pkg::ATTACK_RESET;
			decay_q   <= lae_pkg::DECAY_RESET;
			release_q <= lae_pkg::RELEASE_RESET;
			sustain_q <= LEVEL_BITS'(lae_pkg::SUSTAIN_RESET);
			peak_q    <= LEVEL_BITS'(lae_pkg::PEAK_RESET);
		end else if (cfg_we) begin
			unique case (lae_pkg::cfg_reg_t'(cfg_index))
				lae_pkg::REG_ATTACK:  attack_q  <= cfg_data;
				lae_pkg::REG_DECAY:   decay_q   <= cfg_data;
				lae_pkg::REG_SUSTAIN: sustain_q <= LEVEL_BITS'(cfg_data[CfgLevelW-1:0]);
				lae_pkg::REG_RELEASE: release_q <= cfg_data;
				lae_pkg::REG_PEAK:    peak_q    <= LEVEL_BITS'(cfg_data[CfgLevelW-1:0]);
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Phase decision: pick base level, multiplier operands and divisor
	// -----------------------------------------------------------------------
	always_comb begin
		elapsed = now_q - (gate_q ? on_q : off_q);
		t_w     = CmpBits'(elapsed);
		a_w     = CmpBits'(attack_q);
		ad_w    = CmpBits'(attack_q) + CmpBits'(decay_q);
		r_w     = CmpBits'(release_q);
		dt_w    = t_w - a_w;
		rising  = (sustain_q >= peak_q);

		ev_mode = lae_pkg::MODE_DIRECT;
		ev_base = '0;
		ev_a    = t_w[TickBits-1:0];
		ev_b    = peak_q;
		ev_den  = attack_q;

		if (gate_q) begin
			priority if (t_w <= a_w) begin
				if (attack_q == '0) begin
					ev_base = peak_q;
				end else begin
					ev_mode = lae_pkg::MODE_ADD;
				end
			end else if (t_w <= ad_w) begin
				// decay may head up or down; truncate the magnitude of the step
				ev_mode = rising ? lae_pkg::MODE_ADD : lae_pkg::MODE_SUB;
				ev_base = peak_q;
				ev_a    = dt_w[TickBits-1:0];
				ev_b    = rising ? (sustain_q - peak_q) : (peak_q - sustain_q);
				ev_den  = decay_q;
			end else begin
				ev_base = sustain_q;
			end
		end else begin
			if (t_w < r_w) begin
				ev_mode = lae_pkg::MODE_SUB;
				ev_base = held_q;
				ev_b    = held_q;
				ev_den  = release_q;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Sequencer
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lae_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			lae_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lae_pkg::S_EVAL;
				end
			end
			lae_pkg::S_EVAL: begin
				if (func_q == lae_pkg::FUNC_SAMPLE && ev_mode != lae_pkg::MODE_DIRECT) begin
					state_d = lae_pkg::S_MUL;
				end else begin
					state_d = lae_pkg::S_DONE;
				end
			end
			lae_pkg::S_MUL: begin
				div_start = 1'b1;
				state_d   = lae_pkg::S_DIV;
			end
			lae_pkg::S_DIV: begin
				if (div_done) begin
					state_d = lae_pkg::S_DONE;
				end
			end
			lae_pkg::S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = lae_pkg::S_IDLE;
				end
			end
			default: state_d = lae_pkg::S_IDLE;
		endcase
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= lae_pkg::func_t'(func);
			now_q  <= TIME_BITS'(time_now[InTimeW-1:0]);
		end
		if (state_q == lae_pkg::S_EVAL) begin
			mode_q    <= ev_mode;
			base_q    <= ev_base;
			mul_a_q   <= ev_a;
			mul_b_q   <= ev_b;
			div_den_q <= ev_den;
		end
	end

	assign product = (TickBits + LEVEL_BITS)'(mul_a_q) * (TickBits + LEVEL_BITS)'(mul_b_q);

	lae_div #(
		.DEN_BITS (TickBits),
		.QUO_BITS (LEVEL_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (div_den_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// -----------------------------------------------------------------------
	// Result and state update
	// -----------------------------------------------------------------------
	always_comb begin
		unique case (mode_q)
			lae_pkg::MODE_ADD: lvl = base_q + quotient;
			lae_pkg::MODE_SUB: lvl = base_q - quotient;
			default:           lvl = base_q;
		endcase
		lvl_cut = (lvl <= LEVEL_BITS'(LowCut)) ? '0 : lvl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q      <= 1'b0;
			on_q        <= '0;
			off_q       <= '0;
			held_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				unique case (func_q)
					lae_pkg::FUNC_SAMPLE: begin
						// held level keeps the value before the low cut
						if (gate_q) begin
							held_q <= lvl;
						end
						last_q <= lvl_cut;
					end
					lae_pkg::FUNC_NOTE_ON: begin
						held_q <= '0;
						on_q   <= now_q;
						gate_q <= 1'b1;
					end
					lae_pkg::FUNC_NOTE_OFF: begin
						off_q  <= now_q;
						gate_q <= 1'b0;
					end
					default: begin
						gate_q <= 1'b0;
						last_q <= '0;
						on_q   <= '0;
						off_q  <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			unique case (func_q)
				lae_pkg::FUNC_SAMPLE: begin
					level_q    <= lvl_cut;
					released_q <= !gate_q;
				end
				lae_pkg::FUNC_NOTE_ON: begin
					level_q    <= last_q;
					released_q <= 1'b0;
				end
				lae_pkg::FUNC_NOTE_OFF: begin
					level_q    <= last_q;
					released_q <= 1'b1;
				end
				default: begin
					level_q    <= '0;
					released_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign released  = released_q;

	// -----------------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------------
	a_busy_after_accept : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("block ready again straight after a transaction");

	a_done_in_div : assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == lae_pkg::S_DIV))
		else $error("divider finished outside the divide state");

	a_released_matches_gate : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (released_q == !gate_q))
		else $error("released flag disagrees with gate state");

	a_low_cut : assert property (@(posedge clk) disable iff (!arst_n)
		(last_q == '0) || (last_q > LEVEL_BITS'(LowCut)))
		else $error("stored level inside the low-cut band");

endmodule

>>> bench/linear_adsr_envelope_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_adsr_envelope_checker: envelope predictor and result scoreboard
// Watches the register port and both channels of the envelope core. Every
// accepted input transaction is run through a local copy of the envelope
// state to give the expected level and released flag, which are compared
// field by field with the results as they leave the core, oldest first.
// ---------------------------------------------------------------------------
module linear_adsr_envelope_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [lae_pkg::FUNC_BITS-1:0]      func,
	input  logic [lae_pkg::IN_TIME_BITS-1:0]   time_now,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [lae_pkg::DEF_LEVEL_BITS-1:0] level,
	input  logic                               released,
	input  logic                               cfg_we,
	input  logic [lae_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lae_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 fail_count,
	output int                                 results_owed,
	output int                                 results_checked
);

	localparam int TIME_W  = lae_pkg::DEF_TIME_BITS;
	localparam int LEVEL_W = lae_pkg::DEF_LEVEL_BITS;
	// levels at or below this floor are forced to silence
	localparam int LOW_CUT = (1 << LEVEL_W) / 10000;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               released;
	} envelope_result_t;

	envelope_result_t awaited_results[$];

	logic [lae_pkg::TICK_BITS-1:0] attack_ticks, decay_ticks, release_ticks;
	logic [LEVEL_W-1:0]            sustain_level, peak_level;

	logic               gate_held;
	logic [TIME_W-1:0]  on_time, off_time;
	logic [LEVEL_W-1:0] captured_level, last_level;

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// level while the note is held: attack ramp, decay ramp, then sustain
	function automatic logic [LEVEL_W-1:0] held_ramp(input logic [TIME_W-1:0] t);
		logic [63:0] el, a, d, pk, su, dt, v;
		el = 64'(t);
		a  = 64'(attack_ticks);
		d  = 64'(decay_ticks);
		pk = 64'(peak_level);
		su = 64'(sustain_level);
		if (el <= a) begin
			v = (a == 0) ? pk : (el * pk) / a;
		end else if (el <= a + d) begin
			dt = el - a;
			// an upward decay truncates the size of the step, not the level
			v = (su >= pk) ? pk + (dt * (su - pk)) / d : pk - (dt * (pk - su)) / d;
		end else begin
			v = su;
		end
		return v[LEVEL_W-1:0];
	endfunction

	// level after note off: captured level falling to zero
	function automatic logic [LEVEL_W-1:0] release_ramp(input logic [TIME_W-1:0] t);
		logic [63:0] el, r, hl, v;
		el = 64'(t);
		r  = 64'(release_ticks);
		hl = 64'(captured_level);
		if (el >= r)
			v = 0;
		else
			v = hl - (el * hl) / r;
		return v[LEVEL_W-1:0];
	endfunction

	function automatic envelope_result_t apply_event(input lae_pkg::func_t f,
			input logic [TIME_W-1:0] now);
		logic [LEVEL_W-1:0] lvl;
		envelope_result_t res;
		case (f)
			lae_pkg::FUNC_SAMPLE: begin
				if (gate_held) begin
					lvl = held_ramp(now - on_time);
					captured_level = lvl;
				end else begin
					lvl = release_ramp(now - off_time);
				end
				if (lvl <= LOW_CUT)
					lvl = '0;
				last_level = lvl;
			end
			lae_pkg::FUNC_NOTE_ON: begin
				captured_level = '0;
				on_time = now;
				gate_held = 1'b1;
			end
			lae_pkg::FUNC_NOTE_OFF: begin
				off_time = now;
				gate_held = 1'b0;
			end
			default: begin
				// keep the captured level across a reset code
				gate_held = 1'b0;
				last_level = '0;
				on_time = '0;
				off_time = '0;
			end
		endcase
		res.level = last_level;
		res.released = !gate_held;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		envelope_result_t want;
		if (!arst_n) begin
			attack_ticks = lae_pkg::ATTACK_RESET;
			decay_ticks = lae_pkg::DECAY_RESET;
			release_ticks = lae_pkg::RELEASE_RESET;
			sustain_level = lae_pkg::SUSTAIN_RESET;
			peak_level = lae_pkg::PEAK_RESET;
			gate_held = 1'b0;
			on_time = '0;
			off_time = '0;
			captured_level = '0;
			last_level = '0;
			awaited_results.delete();
			fail_count = 0;
			results_checked = 0;
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (lae_pkg::cfg_reg_t'(cfg_index))
					lae_pkg::REG_ATTACK:  attack_ticks = cfg_data;
					lae_pkg::REG_DECAY:   decay_ticks = cfg_data;
					lae_pkg::REG_SUSTAIN: sustain_level = cfg_data[LEVEL_W-1:0];
					lae_pkg::REG_RELEASE: release_ticks = cfg_data;
					lae_pkg::REG_PEAK:    peak_level = cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			// retire the oldest expectation before queueing a new one
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result level %0d released %0b with none expected",
						level, released));
				end else begin
					want = awaited_results.pop_front();
					if (level !== want.level)
						report_mismatch($sformatf("level %0d, expected %0d", level, want.level));
					if (released !== want.released)
						report_mismatch($sformatf("released %0b, expected %0b",
							released, want.released));
					results_checked++;
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(apply_event(lae_pkg::func_t'(func), time_now));
			results_owed <= awaited_results.size();
		end
	end

endmodule

>>> bench/linear_adsr_envelope_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_adsr_envelope_core_tb: regression for the linear ADSR envelope core
// Drives note on, note off, sample and reset transactions over a range of
// register settings, with random stalls on both channels, and takes the
// verdict from the checker that runs beside the core.
// ---------------------------------------------------------------------------
module linear_adsr_envelope_core_tb;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [lae_pkg::FUNC_BITS-1:0]      func;
	logic [lae_pkg::IN_TIME_BITS-1:0]   time_now;
	logic                               out_valid;
	logic                               out_ready;
	logic [lae_pkg::DEF_LEVEL_BITS-1:0] level;
	logic                               released;
	logic                               cfg_we;
	logic [lae_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [lae_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	int fail_count, results_owed, results_checked;
	int send_idle_pct, recv_idle_pct;
	int func_seen[4];
	int settings_done;

	logic [lae_pkg::TICK_BITS-1:0] cur_attack, cur_decay, cur_release;

	linear_adsr_envelope_core u_dut (.*);

	linear_adsr_envelope_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// a generous ceiling; a healthy run needs a small fraction of it
	initial begin
		#4_000_000;
		$display("linear_adsr_envelope_core regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send(input lae_pkg::func_t f, input logic [31:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		time_now <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		func_seen[f]++;
	endtask

	// hold the sender until every outstanding transaction has returned
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_envelope(input logic [lae_pkg::TICK_BITS-1:0] a,
			input logic [lae_pkg::TICK_BITS-1:0] d, input logic [lae_pkg::TICK_BITS-1:0] r,
			input logic [lae_pkg::CFG_LEVEL_BITS-1:0] s,
			input logic [lae_pkg::CFG_LEVEL_BITS-1:0] p);
		cfg_we <= 1'b1;
		cfg_index <= lae_pkg::REG_ATTACK;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= lae_pkg::REG_DECAY;
		cfg_data <= d;
		@(posedge clk);
		// junk in the upper data bits must be dropped by the level registers
		cfg_index <= lae_pkg::REG_SUSTAIN;
		cfg_data <= {8'($urandom), s};
		@(posedge clk);
		cfg_index <= lae_pkg::REG_RELEASE;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= lae_pkg::REG_PEAK;
		cfg_data <= {8'($urandom), p};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_attack = a;
		cur_decay = d;
		cur_release = r;
		settings_done++;
	endtask

	task automatic choose_setting(input int idx);
		logic [lae_pkg::CFG_LEVEL_BITS-1:0] p;
		case (idx % 9)
			0, 6: program_envelope(24'($urandom_range(1, 16)), 24'($urandom_range(1, 16)),
				24'($urandom_range(1, 16)), 16'($urandom), 16'($urandom));
			1: program_envelope('1, '1, '1, 16'hFFFF, 16'h0000);
			2: program_envelope('0, '0, '0, 16'($urandom), 16'($urandom));
			3: program_envelope(24'd1, 24'd1, 24'd1, 16'h0000, 16'hFFFF);
			4, 7: program_envelope(24'($urandom), 24'($urandom), 24'($urandom),
				16'($urandom), 16'($urandom));
			5: begin
				p = 16'($urandom_range(0, 32767));
				program_envelope(24'($urandom_range(1, 500)), 24'($urandom_range(1, 500)),
					24'($urandom_range(1, 500)), 16'($urandom_range(p, 65535)), p);
			end
			default: program_envelope('0, 24'($urandom_range(1, 40)),
				24'($urandom_range(1, 40)), 16'($urandom), 16'($urandom));
		endcase
	endtask

	// mostly inside the ramp plus a margin past its end, now and then anywhere
	function automatic logic [31:0] pick_offset(input logic [31:0] span);
		if ($urandom_range(9) == 0)
			return $urandom;
		return $urandom_range(0, span + span / 4 + 2);
	endfunction

	task automatic run_random(input int n_target);
		int sent, k, pick;
		logic [31:0] t_on, t_off;
		sent = 0;
		while (sent < n_target) begin
			pick = $urandom_range(99);
			if ($urandom_range(29) == 0)
				wait_drained();
			if (pick < 80) begin
				t_on = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(64) : $urandom;
				send(lae_pkg::FUNC_NOTE_ON, t_on);
				sent++;
				k = $urandom_range(1, 5);
				repeat (k) begin
					send(lae_pkg::FUNC_SAMPLE, t_on + pick_offset(cur_attack + cur_decay));
					sent++;
				end
				if ($urandom_range(4) != 0) begin
					t_off = t_on + pick_offset(cur_attack + cur_decay);
					send(lae_pkg::FUNC_NOTE_OFF, t_off);
					sent++;
					k = $urandom_range(1, 4);
					repeat (k) begin
						send(lae_pkg::FUNC_SAMPLE, t_off + pick_offset(cur_release));
						sent++;
					end
				end
			end else if (pick < 90) begin
				send(lae_pkg::FUNC_RESET, $urandom);
				send(lae_pkg::FUNC_SAMPLE, $urandom);
				sent += 2;
			end else begin
				send(lae_pkg::func_t'($urandom_range(3)), $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		logic [31:0] t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = lae_pkg::FUNC_SAMPLE;
		time_now = '0;
		cfg_we = 1'b0;
		cfg_index = lae_pkg::REG_ATTACK;
		cfg_data = '0;
		settings_done = 0;
		foreach (func_seen[i])
			func_seen[i] = 0;
		send_idle_pct = 29;
		recv_idle_pct = 56;
		cur_attack = lae_pkg::ATTACK_RESET;
		cur_decay = lae_pkg::DECAY_RESET;
		cur_release = lae_pkg::RELEASE_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: sample before any note, then a note that wraps the counter
		send(lae_pkg::FUNC_SAMPLE, 32'd100);
		t = 32'hFFFF_F000;
		send(lae_pkg::FUNC_NOTE_ON, t);
		send(lae_pkg::FUNC_SAMPLE, t);
		send(lae_pkg::FUNC_SAMPLE, t + 32'd2400);
		send(lae_pkg::FUNC_SAMPLE, t + 32'd4800);
		send(lae_pkg::FUNC_SAMPLE, t + 32'd7200);
		send(lae_pkg::FUNC_SAMPLE, t + 32'd200000);
		t = t + 32'd200010;
		send(lae_pkg::FUNC_NOTE_OFF, t);
		send(lae_pkg::FUNC_SAMPLE, t);
		send(lae_pkg::FUNC_SAMPLE, t + 32'd9599);
		send(lae_pkg::FUNC_SAMPLE, t + 32'd9600);
		send(lae_pkg::FUNC_SAMPLE, t - 32'd1);
		send(lae_pkg::FUNC_NOTE_ON, 32'd0);
		send(lae_pkg::FUNC_SAMPLE, 32'hFFFF_FFFF);
		send(lae_pkg::FUNC_RESET, 32'hFFFF_FFFF);
		send(lae_pkg::FUNC_SAMPLE, 32'd5);

		// zero attack, decay and release
		wait_drained();
		program_envelope('0, '0, '0, 16'h1234, 16'hFFFF);
		send(lae_pkg::FUNC_NOTE_ON, 32'h8000_0000);
		send(lae_pkg::FUNC_SAMPLE, 32'h8000_0000);
		send(lae_pkg::FUNC_SAMPLE, 32'h8000_0001);
		send(lae_pkg::FUNC_NOTE_OFF, 32'h8000_0002);
		send(lae_pkg::FUNC_SAMPLE, 32'h8000_0002);

		// upward decay from a peak low enough to hit the low cut
		wait_drained();
		program_envelope(24'd10, 24'd7, 24'd5, 16'hFFFF, 16'd6);
		send(lae_pkg::FUNC_NOTE_ON, 32'd1000);
		send(lae_pkg::FUNC_SAMPLE, 32'd1005);
		send(lae_pkg::FUNC_SAMPLE, 32'd1013);
		send(lae_pkg::FUNC_NOTE_OFF, 32'd1013);
		send(lae_pkg::FUNC_SAMPLE, 32'd1015);

		for (int m = 0; m < 3; m++) begin
			send_idle_pct = (m == 0) ? 29 : (m == 1) ? 56 : 0;
			recv_idle_pct = (m == 0) ? 56 : (m == 1) ? 29 : 0;
			for (int k = 0; k < 3; k++) begin
				wait_drained();
				choose_setting(m * 3 + k);
				run_random(66);
			end
		end
		wait_drained();
		repeat (30) @(posedge clk);

		$display("covered %0d samples, %0d note on, %0d note off, %0d reset codes",
			func_seen[lae_pkg::FUNC_SAMPLE], func_seen[lae_pkg::FUNC_NOTE_ON],
			func_seen[lae_pkg::FUNC_NOTE_OFF], func_seen[lae_pkg::FUNC_RESET]);
		$display("over %0d register settings; %0d results checked, %0d mismatches",
			settings_done, results_checked, fail_count);
		if (fail_count == 0 && results_owed == 0)
			$display("linear_adsr_envelope_core regression: pass");
		else
			$display("linear_adsr_envelope_core regression: fail");
		$finish;
	end

endmodule
